// ===== design/lfdc_pkg.sv =====
`timescale 1ns / 1ps

package lfdc_pkg;

    // Configuration register map
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DETECT_THRESHOLD     = 3'd0,
        CFG_STANDARD_DRIVE       = 3'd1,
        CFG_BOOSTED_DRIVE        = 3'd2,
        CFG_TURN_DRIVE           = 3'd3,
        CFG_LOW_SPEED_THRESHOLD  = 3'd4,
        CFG_HIGH_SPEED_THRESHOLD = 3'd5,
        CFG_STOP_COUNT_LIMIT     = 3'd6,
        CFG_TURN_PULSES          = 3'd7
    } t_cfg_reg;

    // Fixed field widths
    localparam int SPEED_W     = 10;
    localparam int PULSE_W     = 8;
    localparam int TURN_LIM_W  = 10;
    localparam int STOP_LIM_W  = 8;
    localparam int TURN_CNT_W  = 11;
    localparam int NO_LINE_W   = 8;
    localparam int SLOW_CNT_W  = 3;
    localparam int NUM_SENSORS = 6;

    localparam logic [SLOW_CNT_W-1:0] SLOW_RUN_LIMIT = 3'd5;
    localparam logic [TURN_CNT_W-1:0] TURN_CNT_MAX   = 11'd2047;
    localparam logic [NO_LINE_W-1:0]  NO_LINE_MAX    = 8'd255;

    // Reset values of the fixed-width registers
    localparam logic [SPEED_W-1:0]    LOW_SPEED_RST  = 10'd102;
    localparam logic [SPEED_W-1:0]    HIGH_SPEED_RST = 10'd358;
    localparam logic [STOP_LIM_W-1:0] STOP_LIM_RST   = 8'd25;
    localparam logic [TURN_LIM_W-1:0] TURN_LIM_RST   = 10'd310;

    // x*1.15 rounded: x + floor((15x + 50) / 100), the divide by 100 done as
    // a multiply by ceil(2^27 / 100) = 1342178, exact for 15x + 50 < 2^27 / 72.
    localparam int               PCT115_SHIFT = 27;
    localparam int               PCT115_MUL_W = 25;
    localparam logic [24:0]      PCT115_MUL   = 25'd20132670;
    localparam logic [26:0]      PCT115_ADD   = 27'd67108900;

    // x*1.10 rounded: x + floor((x + 5) / 10), divide by 10 as a multiply by
    // ceil(2^19 / 10) = 52429, exact for x + 5 < 2^18.
    localparam int               PCT110_SHIFT = 19;
    localparam int               PCT110_MUL_W = 16;
    localparam logic [15:0]      PCT110_MUL   = 16'd52429;
    localparam logic [18:0]      PCT110_ADD   = 19'd262145;

endpackage

// ===== design/line_follow_drive_controller_core.sv =====
`timescale 1ns / 1ps

// Line-following drive controller core.
//
// Input stream: one transfer per control tick. tdata carries the six raw
// line-sensor samples, the left wheel speed and the two encoder pulse counts;
// tuser carries the turnaround request. Output stream: one transfer per tick
// with the left and right drive levels (unsigned Q0.10) in tdata and the
// left-reverse and turning flags in tuser.
//
// A tick's result is computed from the input register and lands in the
// output register, from which it leaves when the receiver takes it.
// Throughput is one tick per cycle while the receiver keeps up: an input
// register and a result register bracket a single pass of compare, select
// and two constant multiplies. When the receiver stalls, the result holds
// and the input register fills; tready drops only when both are occupied.
//
// Reset (synchronous, active low) loads the register defaults, sets the base
// drive to the standard level, clears all counters, held levels and the turn
// state and empties both pipeline registers. Configuration writes are
// registered directly and are meant for an idle pipeline.
module line_follow_drive_controller_core
    import lfdc_pkg::*;
#(
    parameter int ADC_BITS   = 12,
    parameter int DRIVE_BITS = 10,
    localparam int IN_W       = NUM_SENSORS * ADC_BITS + SPEED_W + 2 * PULSE_W,
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W      = 2 * DRIVE_BITS,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8,
    localparam int CFG_W_A    = (ADC_BITS > DRIVE_BITS) ? ADC_BITS : DRIVE_BITS,
    localparam int CFG_W      = (CFG_W_A > SPEED_W) ? CFG_W_A : SPEED_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_wdata,

    // tick input
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // sensor_one .. sensor_six, left_speed, left_pulses, right_pulses, zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // turn_request
    input  logic [0:0]             i_s_axis_tuser,

    // drive output
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // left_drive, right_drive, zero pad
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // left_reverse, turning
    output logic [1:0]             o_m_axis_tuser
);

    localparam logic [ADC_BITS-1:0]   DETECT_RST = ADC_BITS'(819);
    localparam logic [DRIVE_BITS-1:0] STD_RST    = DRIVE_BITS'(410);
    localparam logic [DRIVE_BITS-1:0] BOOST_RST  = DRIVE_BITS'(614);
    localparam logic [DRIVE_BITS-1:0] TURN_RST   = DRIVE_BITS'(307);
    localparam logic [DRIVE_BITS-1:0] DRIVE_MAX  = '1;
    localparam int P115_W = DRIVE_BITS + PCT115_MUL_W + 2;
    localparam int P110_W = DRIVE_BITS + PCT110_MUL_W + 2;
    localparam int SPD_LSB = NUM_SENSORS * ADC_BITS;
    localparam int LP_LSB  = SPD_LSB + SPEED_W;
    localparam int RP_LSB  = LP_LSB + PULSE_W;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [ADC_BITS-1:0]   r_detect_thr;
    logic [DRIVE_BITS-1:0] r_std_drive;
    logic [DRIVE_BITS-1:0] r_boost_drive;
    logic [DRIVE_BITS-1:0] r_turn_drive;
    logic [SPEED_W-1:0]    r_low_thr;
    logic [SPEED_W-1:0]    r_high_thr;
    logic [STOP_LIM_W-1:0] r_stop_lim;
    logic [TURN_LIM_W-1:0] r_turn_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_detect_thr  <= DETECT_RST;
            r_std_drive   <= STD_RST;
            r_boost_drive <= BOOST_RST;
            r_turn_drive  <= TURN_RST;
            r_low_thr     <= LOW_SPEED_RST;
            r_high_thr    <= HIGH_SPEED_RST;
            r_stop_lim    <= STOP_LIM_RST;
            r_turn_lim    <= TURN_LIM_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DETECT_THRESHOLD:     r_detect_thr  <= i_cfg_wdata[ADC_BITS-1:0];
                CFG_STANDARD_DRIVE:       r_std_drive   <= i_cfg_wdata[DRIVE_BITS-1:0];
                CFG_BOOSTED_DRIVE:        r_boost_drive <= i_cfg_wdata[DRIVE_BITS-1:0];
                CFG_TURN_DRIVE:           r_turn_drive  <= i_cfg_wdata[DRIVE_BITS-1:0];
                CFG_LOW_SPEED_THRESHOLD:  r_low_thr     <= i_cfg_wdata[SPEED_W-1:0];
                CFG_HIGH_SPEED_THRESHOLD: r_high_thr    <= i_cfg_wdata[SPEED_W-1:0];
                CFG_STOP_COUNT_LIMIT:     r_stop_lim    <= i_cfg_wdata[STOP_LIM_W-1:0];
                CFG_TURN_PULSES:          r_turn_lim    <= i_cfg_wdata[TURN_LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake: input register feeds the result register whenever the
    // result slot is empty or being drained this cycle.
    // ---------------------------------------------------------------
    logic r_in_valid;
    logic r_out_valid;
    logic advance;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    // input register (payload needs no reset)
    logic [ADC_BITS-1:0] r_sensor [NUM_SENSORS];
    logic                r_in_req;
    logic [SPEED_W-1:0]  r_in_speed;
    logic [PULSE_W-1:0]  r_in_lp;
    logic [PULSE_W-1:0]  r_in_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            for (int i = 0; i < NUM_SENSORS; i++) begin
                r_sensor[i] <= i_s_axis_tdata[i*ADC_BITS +: ADC_BITS];
            end
            r_in_req   <= i_s_axis_tuser[0];
            r_in_speed <= i_s_axis_tdata[SPD_LSB +: SPEED_W];
            r_in_lp    <= i_s_axis_tdata[LP_LSB +: PULSE_W];
            r_in_rp    <= i_s_axis_tdata[RP_LSB +: PULSE_W];
        end
    end

    // ---------------------------------------------------------------
    // Controller state
    // ---------------------------------------------------------------
    logic [DRIVE_BITS-1:0] r_base,      n_base;
    logic                  r_boosted,   n_boosted;
    logic                  r_reduced,   n_reduced;
    logic [SLOW_CNT_W-1:0] r_slow_cnt,  n_slow_cnt;
    logic [NO_LINE_W-1:0]  r_nl_cnt,    n_nl_cnt;
    logic [DRIVE_BITS-1:0] r_left_lvl,  n_left_lvl;
    logic [DRIVE_BITS-1:0] r_right_lvl, n_right_lvl;
    logic                  r_turn,      n_turn;
    logic [TURN_CNT_W-1:0] r_lcnt,      n_lcnt;
    logic [TURN_CNT_W-1:0] r_rcnt,      n_rcnt;

    // line detection: inverted sample above threshold, i.e. ~s > thr
    logic [NUM_SENSORS-1:0] seen;

    always_comb begin
        for (int i = 0; i < NUM_SENSORS; i++) begin
            seen[i] = (~r_sensor[i]) > r_detect_thr;
        end
    end

    // speed hysteresis, applied on a tick that reaches normal control
    logic [DRIVE_BITS-1:0] spd_base;
    logic                  spd_boosted;
    logic                  spd_reduced;
    logic [SLOW_CNT_W-1:0] spd_slow;

    always_comb begin
        spd_base    = r_base;
        spd_boosted = r_boosted;
        spd_reduced = r_reduced;
        spd_slow    = r_slow_cnt;
        if (r_in_speed < r_low_thr && !r_boosted) begin
            if (r_slow_cnt > SLOW_RUN_LIMIT) begin
                spd_base    = r_boost_drive;
                spd_boosted = 1'b1;
                spd_reduced = 1'b0;
                spd_slow    = '0;
            end else begin
                spd_slow = r_slow_cnt + 1'b1;
            end
        end else if (r_in_speed > r_high_thr && !r_reduced) begin
            spd_base    = r_std_drive;
            spd_boosted = 1'b0;
            spd_reduced = 1'b1;
        end
    end

    // base drive x1.15, x1.10 rounded to nearest, standard x2 and /2, saturated
    logic [P115_W-1:0]     prod115;
    logic [P110_W-1:0]     prod110;
    logic [DRIVE_BITS:0]   sum115;
    logic [DRIVE_BITS:0]   sum110;
    logic [DRIVE_BITS-1:0] base_x115;
    logic [DRIVE_BITS-1:0] base_x110;
    logic [DRIVE_BITS-1:0] std_x2;
    logic [DRIVE_BITS-1:0] std_half;

    assign prod115 = P115_W'(spd_base) * P115_W'(PCT115_MUL) + P115_W'(PCT115_ADD);
    assign prod110 = P110_W'(spd_base) * P110_W'(PCT110_MUL) + P110_W'(PCT110_ADD);
    assign sum115  = {1'b0, spd_base} + (DRIVE_BITS + 1)'(prod115 >> PCT115_SHIFT);
    assign sum110  = {1'b0, spd_base} + (DRIVE_BITS + 1)'(prod110 >> PCT110_SHIFT);
    assign base_x115 = sum115[DRIVE_BITS] ? DRIVE_MAX : sum115[DRIVE_BITS-1:0];
    assign base_x110 = sum110[DRIVE_BITS] ? DRIVE_MAX : sum110[DRIVE_BITS-1:0];
    assign std_x2    = r_std_drive[DRIVE_BITS-1] ? DRIVE_MAX
                                                 : {r_std_drive[DRIVE_BITS-2:0], 1'b0};
    assign std_half  = r_std_drive >> 1;

    function automatic logic [TURN_CNT_W-1:0] count_add(
        input logic [TURN_CNT_W-1:0] cnt,
        input logic [PULSE_W-1:0]    pulses
    );
        logic [TURN_CNT_W:0] sum;
        sum = {1'b0, cnt} + (TURN_CNT_W + 1)'(pulses);
        return sum[TURN_CNT_W] ? TURN_CNT_MAX : sum[TURN_CNT_W-1:0];
    endfunction

    // result of this tick
    logic [DRIVE_BITS-1:0] res_left;
    logic [DRIVE_BITS-1:0] res_right;
    logic                  res_turning;
    logic                  left_run;
    logic                  right_run;
    logic                  normal;

    always_comb begin
        n_base      = r_base;
        n_boosted   = r_boosted;
        n_reduced   = r_reduced;
        n_slow_cnt  = r_slow_cnt;
        n_nl_cnt    = r_nl_cnt;
        n_left_lvl  = r_left_lvl;
        n_right_lvl = r_right_lvl;
        n_turn      = r_turn;
        n_lcnt      = r_lcnt;
        n_rcnt      = r_rcnt;
        res_turning = 1'b0;
        normal      = 1'b1;
        left_run    = 1'b0;
        right_run   = 1'b0;

        // turnaround: count pulses on later ticks, restart counts on the first
        if (r_turn || r_in_req) begin
            if (r_turn) begin
                n_lcnt = count_add(r_lcnt, r_in_lp);
                n_rcnt = count_add(r_rcnt, r_in_rp);
            end else begin
                n_turn = 1'b1;
                n_lcnt = '0;
                n_rcnt = '0;
            end
            left_run  = n_lcnt < TURN_CNT_W'(r_turn_lim);
            right_run = n_rcnt < TURN_CNT_W'(r_turn_lim);
            if (left_run || right_run) begin
                res_turning = 1'b1;
                normal      = 1'b0;
            end else begin
                // turn finished: drop held levels, carry on with normal control
                n_turn      = 1'b0;
                n_left_lvl  = '0;
                n_right_lvl = '0;
            end
        end

        if (normal) begin
            n_base     = spd_base;
            n_boosted  = spd_boosted;
            n_reduced  = spd_reduced;
            n_slow_cnt = spd_slow;

            if (seen == '0) begin
                if (r_nl_cnt > r_stop_lim) begin
                    n_left_lvl  = '0;
                    n_right_lvl = '0;
                    n_nl_cnt    = '0;
                end else if (r_nl_cnt < NO_LINE_MAX) begin
                    n_nl_cnt = r_nl_cnt + 1'b1;
                end
            end else if (seen[4]) begin
                n_base      = r_std_drive;
                n_left_lvl  = std_x2;
                n_right_lvl = std_half;
            end else if (seen[5]) begin
                n_base      = r_std_drive;
                n_left_lvl  = std_half;
                n_right_lvl = std_x2;
            end else if (seen[2]) begin
                n_left_lvl  = base_x115;
                n_right_lvl = spd_base;
            end else if (seen[3]) begin
                n_left_lvl  = spd_base;
                n_right_lvl = base_x115;
            end else if (seen[0] && seen[1]) begin
                n_left_lvl  = spd_base;
                n_right_lvl = spd_base;
            end else if (seen[1]) begin
                n_left_lvl  = spd_base;
                n_right_lvl = base_x110;
                n_nl_cnt    = '0;
            end else begin
                n_left_lvl  = base_x110;
                n_right_lvl = spd_base;
                n_nl_cnt    = '0;
            end
        end
    end

    always_comb begin
        if (res_turning) begin
            res_left  = left_run  ? r_turn_drive : '0;
            res_right = right_run ? r_turn_drive : '0;
        end else begin
            res_left  = n_left_lvl;
            res_right = n_right_lvl;
        end
    end

    // advance state only when the tick moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= STD_RST;
            r_boosted   <= 1'b0;
            r_reduced   <= 1'b0;
            r_slow_cnt  <= '0;
            r_nl_cnt    <= '0;
            r_left_lvl  <= '0;
            r_right_lvl <= '0;
            r_turn      <= 1'b0;
            r_lcnt      <= '0;
            r_rcnt      <= '0;
        end else if (advance) begin
            r_base      <= n_base;
            r_boosted   <= n_boosted;
            r_reduced   <= n_reduced;
            r_slow_cnt  <= n_slow_cnt;
            r_nl_cnt    <= n_nl_cnt;
            r_left_lvl  <= n_left_lvl;
            r_right_lvl <= n_right_lvl;
            r_turn      <= n_turn;
            r_lcnt      <= n_lcnt;
            r_rcnt      <= n_rcnt;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic [DRIVE_BITS-1:0] r_out_left;
    logic [DRIVE_BITS-1:0] r_out_right;
    logic                  r_out_turning;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_left    <= res_left;
            r_out_right   <= res_right;
            r_out_turning <= res_turning;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_TDATA_W'({r_out_right, r_out_left});
    // the left wheel runs backward exactly while turning
    assign o_m_axis_tuser  = {r_out_turning, r_out_turning};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_advance_fills_output: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid
    ) else $error("tick advanced but no result registered");

    a_stall_holds_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_speed)
    ) else $error("stalled tick lost from input register");

    a_flags_exclusive: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !(r_boosted && r_reduced)
    ) else $error("boosted and reduced set together");

    a_slow_count_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_slow_cnt <= SLOW_RUN_LIMIT + 3'd1
    ) else $error("slow tick count ran past its limit");

    a_turn_result_on_turn: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        advance && res_turning |=> r_turn
    ) else $error("turn result without turn state");

endmodule

// ===== bench/lfdc_drive_checker.sv =====
`timescale 1ns / 1ps

// Watches the tick and drive streams of the controller, predicts each drive
// transfer from the accepted ticks and compares it with what comes out.
module lfdc_drive_checker
    import lfdc_pkg::*;
#(
    parameter int ADC_BITS    = 12,
    parameter int DRIVE_BITS  = 10,
    parameter int IN_TDATA_W  = 104,
    parameter int OUT_TDATA_W = 24,
    parameter int CFG_W       = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    input  logic                   i_tick_valid,
    input  logic                   i_tick_ready,
    input  logic [IN_TDATA_W-1:0]  i_tick_data,
    input  logic [0:0]             i_tick_user,
    input  logic                   i_drive_valid,
    input  logic                   i_drive_ready,
    input  logic [OUT_TDATA_W-1:0] i_drive_data,
    input  logic [1:0]             i_drive_user,
    output int                     o_fail_count,
    output int                     o_pending
);

    localparam int ADC_MAX   = (1 << ADC_BITS) - 1;
    localparam int DRIVE_MAX = (1 << DRIVE_BITS) - 1;
    localparam int SPEED_LSB = NUM_SENSORS * ADC_BITS;
    localparam int LP_LSB    = SPEED_LSB + SPEED_W;
    localparam int RP_LSB    = LP_LSB + PULSE_W;

    typedef struct {
        int left_drive;
        int right_drive;
        bit left_reverse;
        bit turning;
    } drive_t;

    drive_t pending_drives[$];
    int     mismatch_count = 0;

    // register copies
    int detect_thr, std_drive, boost_drive, turn_drive;
    int slow_limit, fast_limit, stop_limit, turn_limit;

    // controller state copy
    int base_drive, slow_ticks, no_line_ticks;
    int left_level, right_level, left_turn_cnt, right_turn_cnt;
    bit boosted, reduced, turn_active;

    drive_t got, want;

    assign o_fail_count = mismatch_count;

    function automatic int sat_drive(input int v);
        return (v > DRIVE_MAX) ? DRIVE_MAX : v;
    endfunction

    function automatic int scaled(input int v, input int pct);
        return sat_drive((v * pct + 50) / 100);
    endfunction

    function automatic int add_pulses(input int cnt, input int p);
        return (cnt + p > int'(TURN_CNT_MAX)) ? int'(TURN_CNT_MAX) : cnt + p;
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Work out the drive transfer caused by one tick and advance the state.
    task automatic compute_drive(input logic [IN_TDATA_W-1:0] data, input bit request,
                                 output drive_t d);
        bit [NUM_SENSORS-1:0] seen;
        int  speed, lp, rp;
        bit  left_run, right_run, handled;
        for (int i = 0; i < NUM_SENSORS; i++)
            seen[i] = (ADC_MAX - int'(data[i*ADC_BITS +: ADC_BITS])) > detect_thr;
        speed   = int'(data[SPEED_LSB +: SPEED_W]);
        lp      = int'(data[LP_LSB +: PULSE_W]);
        rp      = int'(data[RP_LSB +: PULSE_W]);
        handled = 1'b0;

        if (turn_active || request) begin
            if (turn_active) begin
                left_turn_cnt  = add_pulses(left_turn_cnt, lp);
                right_turn_cnt = add_pulses(right_turn_cnt, rp);
            end else begin
                // start of a turn: this tick's pulses are not counted
                turn_active    = 1'b1;
                left_turn_cnt  = 0;
                right_turn_cnt = 0;
            end
            left_run  = left_turn_cnt < turn_limit;
            right_run = right_turn_cnt < turn_limit;
            if (left_run || right_run) begin
                d.left_drive   = left_run ? turn_drive : 0;
                d.right_drive  = right_run ? turn_drive : 0;
                d.left_reverse = 1'b1;
                d.turning      = 1'b1;
                handled        = 1'b1;
            end else begin
                // turn complete: drop held levels and fall through to normal control
                turn_active = 1'b0;
                left_level  = 0;
                right_level = 0;
            end
        end

        if (!handled) begin
            if (speed < slow_limit && !boosted) begin
                if (slow_ticks > int'(SLOW_RUN_LIMIT)) begin
                    base_drive = boost_drive;
                    boosted    = 1'b1;
                    reduced    = 1'b0;
                    slow_ticks = 0;
                end else begin
                    slow_ticks = (slow_ticks + 1) & 7;
                end
            end else if (speed > fast_limit && !reduced) begin
                base_drive = std_drive;
                boosted    = 1'b0;
                reduced    = 1'b1;
            end

            if (seen == '0) begin
                if (no_line_ticks > stop_limit) begin
                    left_level    = 0;
                    right_level   = 0;
                    no_line_ticks = 0;
                end else if (no_line_ticks < int'(NO_LINE_MAX)) begin
                    no_line_ticks++;
                end
            end else if (seen[4]) begin
                base_drive  = std_drive;
                left_level  = sat_drive(std_drive * 2);
                right_level = std_drive >> 1;
            end else if (seen[5]) begin
                base_drive  = std_drive;
                left_level  = std_drive >> 1;
                right_level = sat_drive(std_drive * 2);
            end else if (seen[2]) begin
                left_level  = scaled(base_drive, 115);
                right_level = base_drive;
            end else if (seen[3]) begin
                left_level  = base_drive;
                right_level = scaled(base_drive, 115);
            end else if (seen[0] && seen[1]) begin
                left_level  = base_drive;
                right_level = base_drive;
            end else if (seen[1]) begin
                left_level    = base_drive;
                right_level   = scaled(base_drive, 110);
                no_line_ticks = 0;
            end else begin
                left_level    = scaled(base_drive, 110);
                right_level   = base_drive;
                no_line_ticks = 0;
            end
            d.left_drive   = left_level & DRIVE_MAX;
            d.right_drive  = right_level & DRIVE_MAX;
            d.left_reverse = 1'b0;
            d.turning      = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            detect_thr     = 819 & ADC_MAX;
            std_drive      = 410 & DRIVE_MAX;
            boost_drive    = 614 & DRIVE_MAX;
            turn_drive     = 307 & DRIVE_MAX;
            slow_limit     = int'(LOW_SPEED_RST);
            fast_limit     = int'(HIGH_SPEED_RST);
            stop_limit     = int'(STOP_LIM_RST);
            turn_limit     = int'(TURN_LIM_RST);
            base_drive     = std_drive;
            boosted        = 1'b0;
            reduced        = 1'b0;
            slow_ticks     = 0;
            no_line_ticks  = 0;
            left_level     = 0;
            right_level    = 0;
            turn_active    = 1'b0;
            left_turn_cnt  = 0;
            right_turn_cnt = 0;
            pending_drives.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_DETECT_THRESHOLD:     detect_thr  = int'(i_cfg_wdata) & ADC_MAX;
                    CFG_STANDARD_DRIVE:       std_drive   = int'(i_cfg_wdata) & DRIVE_MAX;
                    CFG_BOOSTED_DRIVE:        boost_drive = int'(i_cfg_wdata) & DRIVE_MAX;
                    CFG_TURN_DRIVE:           turn_drive  = int'(i_cfg_wdata) & DRIVE_MAX;
                    CFG_LOW_SPEED_THRESHOLD:  slow_limit  = int'(i_cfg_wdata) & 'h3FF;
                    CFG_HIGH_SPEED_THRESHOLD: fast_limit  = int'(i_cfg_wdata) & 'h3FF;
                    CFG_STOP_COUNT_LIMIT:     stop_limit  = int'(i_cfg_wdata) & 'hFF;
                    CFG_TURN_PULSES:          turn_limit  = int'(i_cfg_wdata) & 'h3FF;
                    default: ;
                endcase
            end
            // compare before predicting: a result never belongs to a tick of the same edge
            if (i_drive_valid && i_drive_ready) begin
                got.left_drive   = int'(i_drive_data[DRIVE_BITS-1:0]);
                got.right_drive  = int'(i_drive_data[2*DRIVE_BITS-1:DRIVE_BITS]);
                got.left_reverse = i_drive_user[0];
                got.turning      = i_drive_user[1];
                if (pending_drives.size() == 0) begin
                    $error("drive transfer with no tick outstanding");
                    mismatch_count++;
                end else begin
                    want = pending_drives.pop_front();
                    check_field("left_drive", want.left_drive, got.left_drive);
                    check_field("right_drive", want.right_drive, got.right_drive);
                    check_field("left_reverse", want.left_reverse, got.left_reverse);
                    check_field("turning", want.turning, got.turning);
                end
            end
            if (i_tick_valid && i_tick_ready) begin
                compute_drive(i_tick_data, i_tick_user[0], want);
                pending_drives.push_back(want);
            end
        end
        o_pending <= pending_drives.size();
    end

endmodule

// ===== bench/line_follow_drive_controller_core_test.sv =====
`timescale 1ns / 1ps

module line_follow_drive_controller_core_test;
    import lfdc_pkg::*;

    localparam int ADC_BITS    = 12;
    localparam int DRIVE_BITS  = 10;
    localparam int ADC_MAX     = (1 << ADC_BITS) - 1;
    localparam int IN_TDATA_W  = ((NUM_SENSORS * ADC_BITS + SPEED_W + 2 * PULSE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * DRIVE_BITS + 7) / 8) * 8;
    localparam int CFG_W       = (ADC_BITS > DRIVE_BITS) ? ADC_BITS : DRIVE_BITS;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_TICKS = 125;

    // one control tick as it travels on the input stream
    typedef struct packed {
        logic [PULSE_W-1:0]                   right_pulses;
        logic [PULSE_W-1:0]                   left_pulses;
        logic [SPEED_W-1:0]                   speed;
        logic [NUM_SENSORS-1:0][ADC_BITS-1:0] sample;
    } tick_t;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index     = '0;
    logic [CFG_W-1:0]       i_cfg_wdata     = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // sensor_one .. sensor_six, left_speed, left_pulses, right_pulses, zero pad
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    // turn_request
    logic [0:0]             i_s_axis_tuser  = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b1;
    // left_drive, right_drive, zero pad
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    // left_reverse, turning
    logic [1:0]             o_m_axis_tuser;

    int fail_count;
    int pending;
    int cycles     = 0;
    int burst_left = 0;
    int stall_left = 0;
    int stall_mode = 0;
    int scene      = 0;

    // copies of the registers that shape the stimulus
    int cur_thr  = 819;
    int cur_low  = int'(LOW_SPEED_RST);
    int cur_high = int'(HIGH_SPEED_RST);

    always #5 i_clk = ~i_clk;

    line_follow_drive_controller_core #(
        .ADC_BITS   (ADC_BITS),
        .DRIVE_BITS (DRIVE_BITS)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    lfdc_drive_checker #(
        .ADC_BITS    (ADC_BITS),
        .DRIVE_BITS  (DRIVE_BITS),
        .IN_TDATA_W  (IN_TDATA_W),
        .OUT_TDATA_W (OUT_TDATA_W),
        .CFG_W       (CFG_W)
    ) drive_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_tick_valid  (i_s_axis_tvalid),
        .i_tick_ready  (o_s_axis_tready),
        .i_tick_data   (i_s_axis_tdata),
        .i_tick_user   (i_s_axis_tuser),
        .i_drive_valid (o_m_axis_tvalid),
        .i_drive_ready (i_m_axis_tready),
        .i_drive_data  (o_m_axis_tdata),
        .i_drive_user  (o_m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // Hard stop: a hung handshake or a lost transfer ends here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver back-pressure: segments of always-ready, solid stalls, coin flips
    // and alternation, so stalls land on every phase of the pipeline.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = (stall_mode == 1) ? $urandom_range(1, 12) : $urandom_range(4, 40);
        end
        stall_left--;
        case (stall_mode)
            0:       i_m_axis_tready = 1'b1;
            1:       i_m_axis_tready = 1'b0;
            2:       i_m_axis_tready = 1'($urandom_range(0, 1));
            default: i_m_axis_tready = ~i_m_axis_tready;
        endcase
    end

    // Offer one tick and hold it until the transfer; open a new burst after a
    // random gap once the current one is spent.
    task automatic send_tick(input tick_t t, input bit request);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        i_s_axis_tdata  = IN_TDATA_W'(t);
        i_s_axis_tuser  = request;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        burst_left--;
    endtask

    task automatic write_reg(input t_cfg_reg index, input int value);
        i_cfg_we    = 1'b1;
        i_cfg_index = index;
        i_cfg_wdata = CFG_W'(value);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Drain the pipeline, then load every register.
    task automatic set_config(input int thr, input int std_drv, input int boost_drv,
                              input int turn_drv, input int low, input int high,
                              input int stop_lim, input int turn_lim);
        wait (pending == 0);
        repeat (4) @(negedge i_clk);
        write_reg(CFG_DETECT_THRESHOLD, thr);
        write_reg(CFG_STANDARD_DRIVE, std_drv);
        write_reg(CFG_BOOSTED_DRIVE, boost_drv);
        write_reg(CFG_TURN_DRIVE, turn_drv);
        write_reg(CFG_LOW_SPEED_THRESHOLD, low);
        write_reg(CFG_HIGH_SPEED_THRESHOLD, high);
        write_reg(CFG_STOP_COUNT_LIMIT, stop_lim);
        write_reg(CFG_TURN_PULSES, turn_lim);
        cur_thr  = thr;
        cur_low  = low;
        cur_high = high;
    endtask

    // Directed tick: a set mask bit puts a sensor hard on the line, a clear one
    // puts it at full scale.
    function automatic tick_t masked_tick(input bit [NUM_SENSORS-1:0] mask, input int speed,
                                          input int lp, input int rp);
        tick_t t;
        for (int i = 0; i < NUM_SENSORS; i++)
            t.sample[i] = mask[i] ? '0 : ADC_BITS'(ADC_MAX);
        t.speed        = SPEED_W'(speed);
        t.left_pulses  = PULSE_W'(lp);
        t.right_pulses = PULSE_W'(rp);
        return t;
    endfunction

    // Sample on or off the line for the current threshold, with the odd edge
    // value; fall back to the full range at random, and always when the line cannot be seen.
    function automatic int line_sample(input bit on_line);
        if (cur_thr >= ADC_MAX || $urandom_range(0, 4) == 0)
            return $urandom_range(0, ADC_MAX);
        if (on_line)
            return ($urandom_range(0, 7) == 0) ? ADC_MAX - 1 - cur_thr
                                               : $urandom_range(0, ADC_MAX - 1 - cur_thr);
        return ($urandom_range(0, 7) == 0) ? ADC_MAX - cur_thr
                                           : $urandom_range(ADC_MAX - cur_thr, ADC_MAX);
    endfunction

    function automatic int rand_pulses();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return 0;
        if (r == 2)
            return 255;
        return $urandom_range(0, 255);
    endfunction

    // Scenes hold for a while so that lost-line runs, single-sensor tracking
    // and slow runs build up long enough to reach the stop and boost logic.
    function automatic tick_t random_tick();
        tick_t                t;
        bit [NUM_SENSORS-1:0] mask;
        int                   r;
        if ($urandom_range(0, 29) == 0)
            scene = $urandom_range(0, 3);
        case (scene)
            0: for (int i = 0; i < NUM_SENSORS; i++) mask[i] = ($urandom_range(0, 9) < 3);
            1: mask = '0;
            2: mask = ($urandom_range(0, 6) == 0) ? NUM_SENSORS'(3)
                                                  : NUM_SENSORS'(1) << $urandom_range(0, 5);
            default: mask = '0;
        endcase
        for (int i = 0; i < NUM_SENSORS; i++)
            t.sample[i] = (scene == 3) ? ADC_BITS'($urandom_range(0, ADC_MAX))
                                       : ADC_BITS'(line_sample(mask[i]));
        r = $urandom_range(0, 4);
        if (r < 2)
            t.speed = SPEED_W'($urandom_range(0, cur_low));
        else if (r < 4)
            t.speed = SPEED_W'($urandom_range(cur_high, 1023));
        else
            t.speed = SPEED_W'($urandom_range(0, 1023));
        t.left_pulses  = PULSE_W'(rand_pulses());
        t.right_pulses = PULSE_W'(rand_pulses());
        return t;
    endfunction

    initial begin
        tick_t t;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed pass at reset settings: every steering rule, the held case,
        // the slow run into boost, the fast return to standard and a full turn.
        send_tick(masked_tick(6'h00, 0, 0, 0), 1'b0);
        send_tick(masked_tick(6'h3F, 1023, 255, 255), 1'b0);
        send_tick(masked_tick(6'h10, 0, 0, 0), 1'b0);
        send_tick(masked_tick(6'h20, 0, 0, 0), 1'b0);
        send_tick(masked_tick(6'h04, 0, 0, 0), 1'b0);
        send_tick(masked_tick(6'h08, 0, 0, 0), 1'b0);
        send_tick(masked_tick(6'h03, 0, 0, 0), 1'b0);
        send_tick(masked_tick(6'h02, 0, 0, 0), 1'b0);
        send_tick(masked_tick(6'h01, 512, 0, 0), 1'b0);
        // threshold edge: sensor one one step inside, the rest exactly at it
        t = masked_tick(6'h00, 200, 0, 0);
        for (int i = 0; i < NUM_SENSORS; i++)
            t.sample[i] = ADC_BITS'(ADC_MAX - cur_thr);
        t.sample[0] = ADC_BITS'(ADC_MAX - cur_thr - 1);
        send_tick(t, 1'b0);
        send_tick(masked_tick(6'h00, 200, 0, 0), 1'b0);
        // turn start ignores this tick's pulses; a second request mid-turn is dropped
        send_tick(masked_tick(6'h3F, 200, 255, 255), 1'b1);
        send_tick(masked_tick(6'h00, 200, 255, 0), 1'b1);
        send_tick(masked_tick(6'h00, 200, 255, 255), 1'b0);
        send_tick(masked_tick(6'h03, 200, 0, 255), 1'b0);
        send_tick(masked_tick(6'h01, 1023, 0, 0), 1'b0);

        // Random phases across settings, extremes included; last phase restores
        // the reset values.
        for (int p = 0; p < 8; p++) begin
            case (p)
                1: set_config(0, 0, 0, 0, 0, 0, 0, 0);
                2: set_config(ADC_MAX, 1023, 1023, 1023, 1023, 1023, 254, 1023);
                7: set_config(819, 410, 614, 307, 102, 358, 25, 310);
                default:
                    set_config($urandom_range(0, 7) == 0 ? $urandom_range(0, ADC_MAX)
                                                         : $urandom_range(200, 3800),
                               $urandom_range(0, 1023), $urandom_range(0, 1023),
                               $urandom_range(0, 1023), $urandom_range(0, 400),
                               $urandom_range(200, 1023),
                               $urandom_range(0, 7) == 0 ? $urandom_range(0, 254)
                                                         : $urandom_range(0, 40),
                               $urandom_range(0, 1023));
            endcase
            for (int n = 0; n < PHASE_TICKS; n++)
                send_tick(random_tick(), $urandom_range(0, 24) == 0);
        end

        wait (pending == 0);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== line_follow_drive_controller_core.f =====
design/lfdc_pkg.sv
design/line_follow_drive_controller_core.sv
bench/lfdc_drive_checker.sv
bench/line_follow_drive_controller_core_test.sv
